>>> rtl/keypad_scan_debouncer_unit_defines.svh
// Assertion macros for the keypad debouncer RTL.
`ifndef KEYPAD_SCAN_DEBOUNCER_UNIT_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KSD_ASSERT_IMPL(lbl, ante, cons, msg)
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/ksd_pkg.sv
`timescale 1ns / 1ps

package ksd_pkg;

  localparam int unsigned NUM_COLUMNS_DEF = 4;
  localparam int unsigned NUM_ROWS_DEF    = 4;

  localparam logic [3:0] LIMIT_RESET = 4'd3;

  // request kinds
  localparam logic [1:0] REQ_SCAN   = 2'd0;
  localparam logic [1:0] REQ_CHECK  = 2'd1;
  localparam logic [1:0] REQ_CLRF   = 2'd2;
  localparam logic [1:0] REQ_RESET  = 2'd3;

  // key phases
  localparam logic [1:0] PH_RELEASED    = 2'd0;
  localparam logic [1:0] PH_PRESS_DEB   = 2'd1;
  localparam logic [1:0] PH_PRESSED     = 2'd2;
  localparam logic [1:0] PH_RELEASE_DEB = 2'd3;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] count;
  } key_st_t;

  localparam int unsigned KEY_ST_W = $bits(key_st_t);

endpackage

>>> rtl/ksd_ram.sv
`timescale 1ns / 1ps

module ksd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ksd_col_update.sv
`timescale 1ns / 1ps

// Next phase/count and flag-set strobe for every key of one column.
module ksd_col_update import ksd_pkg::*; #(
  parameter int unsigned NUM_ROWS = NUM_ROWS_DEF
) (
  input  key_st_t [NUM_ROWS-1:0] cur_i,
  input  logic    [NUM_ROWS-1:0] down_i,
  input  logic    [3:0]          limit_i,
  output key_st_t [NUM_ROWS-1:0] nxt_o,
  output logic    [NUM_ROWS-1:0] set_flag_o
);

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      logic [3:0] inc;
      logic       settle;
      inc    = (cur_i[r].count == 4'hF) ? 4'hF : cur_i[r].count + 4'd1;
      settle = (inc >= limit_i);
      nxt_o[r]      = cur_i[r];
      set_flag_o[r] = 1'b0;
      unique case (cur_i[r].phase)
        PH_RELEASED: begin
          if (down_i[r]) begin
            nxt_o[r]      = '{phase: PH_PRESS_DEB, count: 4'd0};
            set_flag_o[r] = 1'b1;
          end
        end
        PH_PRESS_DEB: begin
          if (!down_i[r]) begin
            nxt_o[r] = '{phase: PH_RELEASE_DEB, count: 4'd0};
          end else if (settle) begin
            nxt_o[r] = '{phase: PH_PRESSED, count: 4'd0};
          end else begin
            nxt_o[r].count = inc;
          end
        end
        PH_PRESSED: begin
          if (!down_i[r]) begin
            nxt_o[r] = '{phase: PH_RELEASE_DEB, count: 4'd0};
          end
        end
        PH_RELEASE_DEB: begin
          if (down_i[r]) begin
            nxt_o[r] = '{phase: PH_PRESS_DEB, count: 4'd0};
          end else if (settle) begin
            nxt_o[r] = '{phase: PH_RELEASED, count: 4'd0};
          end else begin
            nxt_o[r].count = inc;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/keypad_scan_debouncer_unit.sv
`timescale 1ns / 1ps
// Matrix keypad debouncer, NUM_ROWS x NUM_COLUMNS keys, key index row*NUM_COLUMNS+column.
// Input channel (in_valid_i/in_ready_o): one request per transaction; req_type_i
//   selects column scan, check-and-clear of one key flag, clear all flags or
//   reset all key state. Every request yields exactly one result transaction.
// Output channel (out_valid_o/out_ready_i): key_was_pressed_o, 1 only for a check
//   that found the key's sticky flag set.
// Config channel (cfg_valid_i/cfg_ready_o): writes debounce_limit_i; always ready.
//   Write it only while no request is in flight.
// Flow: RAM read at the accepting edge, then update into the output register.
//   Throughput: one request per cycle while the output is not stalled; each
//   per-column RAM takes one read and one write per cycle, and a back-to-back
//   hit on the same column is served from a write-forward register.
// Stall: a pending result is held in the output register; the request behind it
//   waits in the execute stage and input ready drops only while both are full.
// Reset: valid bits per RAM row clear at once, so all keys read released with
//   count 0 and flag 0 from the first cycle; debounce limit returns to 3.
//   A reset-all request clears the same valid bits and leaves the limit.
module keypad_scan_debouncer_unit import ksd_pkg::*; #(
  parameter int unsigned NUM_COLUMNS = NUM_COLUMNS_DEF,
  parameter int unsigned NUM_ROWS    = NUM_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] debounce_limit_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [1:0] column_i,
  input  logic [3:0] line_levels_i,
  input  logic [3:0] key_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       key_was_pressed_o
);

`include "keypad_scan_debouncer_unit_defines.svh"

  localparam int unsigned CW   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned RW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned ST_W = NUM_ROWS * KEY_ST_W;

  // config register
  logic [3:0] limit_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= debounce_limit_i;
    end
  end

  // ---------------- stage 0: decode, RAM read ----------------
  logic          in_fire;
  logic          col_ok;
  logic          chk_ok;
  logic [RW-1:0] chk_row;
  logic [CW-1:0] chk_col;
  logic [CW-1:0] rd_addr;
  logic          rd_en;
  logic          req_ok;

  assign in_fire = in_valid_i && in_ready_o;
  assign col_ok  = int'(column_i) < NUM_COLUMNS;

  // key index -> (row, column) by range compare per row
  always_comb begin
    chk_ok  = 1'b0;
    chk_row = '0;
    chk_col = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (int'(key_index_i) >= r * NUM_COLUMNS &&
          int'(key_index_i) < (r + 1) * NUM_COLUMNS) begin
        chk_ok  = 1'b1;
        chk_row = RW'(r);
        chk_col = CW'(int'(key_index_i) - r * NUM_COLUMNS);
      end
    end
  end

  assign rd_addr = (req_type_i == REQ_SCAN) ? CW'(column_i) : chk_col;
  assign req_ok  = ((req_type_i == REQ_SCAN) && col_ok) ||
                   ((req_type_i == REQ_CHECK) && chk_ok);
  assign rd_en   = in_fire && req_ok;

  // ---------------- stage 1: execute ----------------
  logic                s1_valid_q;
  logic [1:0]          s1_req_q;
  logic                s1_ok_q;
  logic [CW-1:0]       s1_addr_q;
  logic [RW-1:0]       s1_row_q;
  logic [NUM_ROWS-1:0] s1_down_q;
  logic                exec;
  logic                out_valid_q;
  logic                out_key_q;

  assign exec       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (exec) begin
      s1_valid_q <= 1'b0;
    end
  end

  // missing level bits above the field read as 0, i.e. key down
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q  <= req_type_i;
      s1_ok_q   <= req_ok;
      s1_addr_q <= rd_addr;
      s1_row_q  <= chk_row;
      s1_down_q <= ~NUM_ROWS'(line_levels_i);
    end
  end

  // RAMs and row valid bits
  logic [ST_W-1:0]        st_rdata;
  logic [NUM_ROWS-1:0]    fl_rdata;
  logic [NUM_COLUMNS-1:0] st_vld_q, st_vld_d;
  logic [NUM_COLUMNS-1:0] fl_vld_q, fl_vld_d;
  logic                   st_we, fl_we;
  logic [ST_W-1:0]        st_wdata;
  logic [NUM_ROWS-1:0]    fl_wdata;

  // last write per RAM, covers a read issued in the same cycle as that write
  logic                fwd_st_vld_q, fwd_fl_vld_q;
  logic [CW-1:0]       fwd_st_addr_q, fwd_fl_addr_q;
  logic [ST_W-1:0]     fwd_st_q;
  logic [NUM_ROWS-1:0] fwd_fl_q;

  ksd_ram #(.WIDTH(ST_W), .DEPTH(NUM_COLUMNS)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_addr_q),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  ksd_ram #(.WIDTH(NUM_ROWS), .DEPTH(NUM_COLUMNS)) u_fl_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (s1_addr_q),
    .wdata_i (fl_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (fl_rdata)
  );

  key_st_t [NUM_ROWS-1:0] st_cur, st_nxt;
  logic    [NUM_ROWS-1:0] fl_cur, fl_set;
  logic                   chk_hit;

  always_comb begin
    if (fwd_st_vld_q && (fwd_st_addr_q == s1_addr_q)) begin
      st_cur = fwd_st_q;
    end else if (st_vld_q[s1_addr_q]) begin
      st_cur = st_rdata;
    end else begin
      st_cur = '0;
    end
    if (fwd_fl_vld_q && (fwd_fl_addr_q == s1_addr_q)) begin
      fl_cur = fwd_fl_q;
    end else if (fl_vld_q[s1_addr_q]) begin
      fl_cur = fl_rdata;
    end else begin
      fl_cur = '0;
    end
  end

  ksd_col_update #(.NUM_ROWS(NUM_ROWS)) u_col_update (
    .cur_i      (st_cur),
    .down_i     (s1_down_q),
    .limit_i    (limit_q),
    .nxt_o      (st_nxt),
    .set_flag_o (fl_set)
  );

  assign chk_hit = (s1_req_q == REQ_CHECK) && s1_ok_q && fl_cur[s1_row_q];

  always_comb begin
    st_we    = 1'b0;
    fl_we    = 1'b0;
    st_wdata = st_nxt;
    fl_wdata = fl_cur | fl_set;
    st_vld_d = st_vld_q;
    fl_vld_d = fl_vld_q;
    if (exec) begin
      unique case (s1_req_q)
        REQ_SCAN: begin
          if (s1_ok_q) begin
            st_we               = 1'b1;
            fl_we               = 1'b1;
            st_vld_d[s1_addr_q] = 1'b1;
            fl_vld_d[s1_addr_q] = 1'b1;
          end
        end
        REQ_CHECK: begin
          fl_wdata           = fl_cur;
          fl_wdata[s1_row_q] = 1'b0;
          if (s1_ok_q) begin
            fl_we               = 1'b1;
            fl_vld_d[s1_addr_q] = 1'b1;
          end
        end
        REQ_CLRF: begin
          fl_vld_d = '0;
        end
        REQ_RESET: begin
          st_vld_d = '0;
          fl_vld_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q     <= '0;
      fl_vld_q     <= '0;
      fwd_st_vld_q <= 1'b0;
      fwd_fl_vld_q <= 1'b0;
    end else begin
      st_vld_q <= st_vld_d;
      fl_vld_q <= fl_vld_d;
      if (st_we) begin
        fwd_st_vld_q <= 1'b1;
      end else if (exec && (s1_req_q == REQ_RESET)) begin
        fwd_st_vld_q <= 1'b0;
      end
      if (fl_we) begin
        fwd_fl_vld_q <= 1'b1;
      end else if (exec && ((s1_req_q == REQ_RESET) || (s1_req_q == REQ_CLRF))) begin
        fwd_fl_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      fwd_st_addr_q <= s1_addr_q;
      fwd_st_q      <= st_wdata;
    end
    if (fl_we) begin
      fwd_fl_addr_q <= s1_addr_q;
      fwd_fl_q      <= fl_wdata;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_key_q <= chk_hit;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_was_pressed_o = out_key_q;

  // ---------------- assertions ----------------
  `KSD_ASSERT_IMPL(a_empty_ready, !s1_valid_q, in_ready_o, "execute stage empty but not ready")
  `KSD_ASSERT_NEXT(a_stall_hold, s1_valid_q && !exec, s1_valid_q, "stalled request dropped")
  `KSD_ASSERT_NEXT(a_reset_all, exec && (s1_req_q == REQ_RESET), (st_vld_q == '0) && (fl_vld_q == '0), "reset-all left valid rows")
  `KSD_ASSERT_NEXT(a_clr_flags, exec && (s1_req_q == REQ_CLRF), fl_vld_q == '0, "clear-flags left valid rows")
  `KSD_ASSERT_IMPL(a_hit_check, exec && chk_hit, (s1_req_q == REQ_CHECK) && fl_we, "flag hit without clear write")

endmodule
